// File: rtl/greedy_edge_partitioner_unit_assert.svh
// ----------------------------------------------------------------------------
// Greedy edge partitioner assertion macros
// Shared property templates for the checker of the partitioner unit.
// ----------------------------------------------------------------------------
`ifndef GREEDY_EDGE_PARTITIONER_UNIT_ASSERT_SVH
`define GREEDY_EDGE_PARTITIONER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define GEP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define GEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gep_pkg.sv
// ----------------------------------------------------------------------------
// gep_pkg
// Types, field widths, register map and rule codes of the edge partitioner.
// ----------------------------------------------------------------------------
`default_nettype none

package gep_pkg;

    // Default build configuration
    localparam int MAX_PARTITIONS_DEF = 16;
    localparam int VERTEX_COUNT_DEF   = 65536;
    localparam int LOAD_WIDTH_DEF     = 32;

    // Word field widths
    localparam int VERTEX_W   = 16;
    localparam int PART_W     = 4;
    localparam int RULE_W     = 2;
    localparam int LOAD_OUT_W = 32;

    // Register map
    localparam int CFG_W      = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE = 1'b0;
    localparam int ACTIVE_RST = 16;

    // Selection rule codes
    localparam logic [RULE_W-1:0] RULE_SHARED = 2'd0;
    localparam logic [RULE_W-1:0] RULE_UNION  = 2'd1;
    localparam logic [RULE_W-1:0] RULE_GLOBAL = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP_Q,
        S_WRAP_R,
        S_READ,
        S_PICK,
        S_REDUCE,
        S_WR_DST
    } t_state;

    // Reset value of the partition count, clamped to the built maximum
    function automatic int active_reset(int max_parts);
        return (ACTIVE_RST > max_parts) ? max_parts : ACTIVE_RST;
    endfunction

endpackage

`default_nettype wire

// File: rtl/greedy_edge_partitioner_unit.sv
// ----------------------------------------------------------------------------
// greedy_edge_partitioner_unit
// Greedy vertex-cut edge partitioner with a per-vertex membership memory.
// ----------------------------------------------------------------------------
// Each input word is one edge (source and destination vertex id); each edge
// produces exactly one result word with the chosen partition, the rule that
// chose it (shared, union, global) and the partition's saturating load after
// the assignment. After reset the membership memory is swept clear, one entry
// per cycle, over all VERTEX_COUNT entries; no edge is taken during that
// sweep, but the register port works. An accepted edge then passes through
// WRAP_Q and WRAP_R (vertex id reduction, only when VERTEX_COUNT is not a
// power of two and is below 65536), READ, PICK, REDUCE and WR_DST before the
// next one can be accepted. REDUCE waits for the min-load search, which
// resolves one tree level per cycle, and the single write port of the
// membership memory writes back both endpoints on successive cycles.
// The result register lets a finished word wait while the next edge is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_edge_partitioner_unit #(
    parameter int MAX_PARTITIONS = gep_pkg::MAX_PARTITIONS_DEF,
    parameter int VERTEX_COUNT   = gep_pkg::VERTEX_COUNT_DEF,
    parameter int LOAD_WIDTH     = gep_pkg::LOAD_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Edge input
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [gep_pkg::VERTEX_W-1:0]     i_source_vertex,
    input  wire logic [gep_pkg::VERTEX_W-1:0]     i_dest_vertex,
    // Result output
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [gep_pkg::PART_W-1:0]            o_chosen_partition,
    output logic [gep_pkg::RULE_W-1:0]            o_rule_used,
    output logic [gep_pkg::LOAD_OUT_W-1:0]        o_load_after,
    // Register port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [gep_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [gep_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gep_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam int VERTEX_W = gep_pkg::VERTEX_W;
    localparam int CFG_W    = gep_pkg::CFG_W;
    localparam int VADDR_W  = $clog2(VERTEX_COUNT);
    localparam int IDX_W    = $clog2(MAX_PARTITIONS);
    localparam int CNT_MIN  = $clog2(MAX_PARTITIONS + 1);
    localparam int EFF_W    = (CNT_MIN > CFG_W) ? CNT_MIN : CFG_W;

    // Vertex id reduction for a store that is not a power of two
    localparam bit NEED_WRAP = (VERTEX_COUNT < (1 << VERTEX_W)) &&
                               ((VERTEX_COUNT & (VERTEX_COUNT - 1)) != 0);
    localparam int REM_W  = VERTEX_W + 1;
    localparam int PROD_W = VERTEX_W + 32;
    localparam int QN_W   = VERTEX_W + REM_W;
    localparam logic [31:0]      WRAP_RECIP = 32'((64'd1 << 32) / VERTEX_COUNT);
    localparam logic [REM_W-1:0] WRAP_MOD   = REM_W'(VERTEX_COUNT);

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    gep_pkg::t_state r_state, n_state;

    logic [CFG_W-1:0]          r_active;
    logic [VERTEX_W-1:0]       r_src_id, r_dst_id;
    logic [VERTEX_W-1:0]       r_src_q, r_dst_q;
    logic [REM_W-1:0]          r_src_rem, r_dst_rem;
    logic [VADDR_W-1:0]        r_clr_addr;

    logic [MAX_PARTITIONS-1:0] r_member_mem [VERTEX_COUNT];
    logic [MAX_PARTITIONS-1:0] r_src_bits, r_dst_bits;

    logic [LOAD_WIDTH-1:0]     r_load [MAX_PARTITIONS];
    logic [gep_pkg::RULE_W-1:0] r_rule;

    logic [gep_pkg::PART_W-1:0]     r_res_part;
    logic [gep_pkg::RULE_W-1:0]     r_res_rule;
    logic [gep_pkg::LOAD_OUT_W-1:0] r_res_load;

    logic                           r_out_valid;
    logic [gep_pkg::PART_W-1:0]     r_out_part;
    logic [gep_pkg::RULE_W-1:0]     r_out_rule;
    logic [gep_pkg::LOAD_OUT_W-1:0] r_out_load;

    logic                      in_acc;
    logic                      out_free;
    logic                      mem_rd_en;
    logic                      mem_we;
    logic [VADDR_W-1:0]        mem_waddr;
    logic [MAX_PARTITIONS-1:0] mem_wdata;
    logic                      sel_start;
    logic                      res_en;
    logic                      out_load;

    logic [PROD_W-1:0]         src_prod, dst_prod;
    logic [QN_W-1:0]           src_qn, dst_qn;
    logic [VADDR_W-1:0]        src_addr, dst_addr;

    logic [EFF_W-1:0]          eff_count;
    logic [MAX_PARTITIONS-1:0] part_mask;
    logic [MAX_PARTITIONS-1:0] src_m, dst_m, shared_m, union_m, cand_m;
    logic [gep_pkg::RULE_W-1:0] cand_rule;

    logic [MAX_PARTITIONS-1:0][LOAD_WIDTH-1:0] load_vec;
    logic                      sel_busy;
    logic [IDX_W-1:0]          sel_index;
    logic [MAX_PARTITIONS-1:0] part_bit;
    logic [LOAD_WIDTH-1:0]     cur_load, new_load;

    logic                         apb_wr;
    logic [gep_pkg::REG_IDX_W-1:0] reg_idx;

    // Remainder correction: value is below twice the store depth
    function automatic logic [VADDR_W-1:0] wrap_fold(logic [REM_W-1:0] rem);
        logic [REM_W-1:0] fixed;
        fixed = (rem >= WRAP_MOD) ? (rem - WRAP_MOD) : rem;
        return VADDR_W'(fixed);
    endfunction

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[gep_pkg::APB_ADDR_W-1:2];
    assign apb_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == gep_pkg::REG_ACTIVE) ?
                     gep_pkg::APB_DATA_W'(r_active) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_W'(gep_pkg::active_reset(MAX_PARTITIONS));
        end else if (apb_wr && (reg_idx == gep_pkg::REG_ACTIVE)) begin
            r_active <= pwdata[CFG_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    assign o_ready  = (r_state == gep_pkg::S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gep_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_rd_en = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = src_addr;
        mem_wdata = r_src_bits | part_bit;
        sel_start = 1'b0;
        res_en    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            gep_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == VADDR_W'(VERTEX_COUNT - 1)) begin
                    n_state = gep_pkg::S_IDLE;
                end
            end
            gep_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = NEED_WRAP ? gep_pkg::S_WRAP_Q : gep_pkg::S_READ;
                end
            end
            gep_pkg::S_WRAP_Q: begin
                n_state = gep_pkg::S_WRAP_R;
            end
            gep_pkg::S_WRAP_R: begin
                n_state = gep_pkg::S_READ;
            end
            gep_pkg::S_READ: begin
                mem_rd_en = 1'b1;
                n_state   = gep_pkg::S_PICK;
            end
            gep_pkg::S_PICK: begin
                sel_start = 1'b1;
                n_state   = gep_pkg::S_REDUCE;
            end
            gep_pkg::S_REDUCE: begin
                // search done: write back source, bump load, stage the result
                if (!sel_busy) begin
                    mem_we  = 1'b1;
                    res_en  = 1'b1;
                    n_state = gep_pkg::S_WR_DST;
                end
            end
            gep_pkg::S_WR_DST: begin
                mem_we    = 1'b1;
                mem_waddr = dst_addr;
                mem_wdata = r_dst_bits | part_bit;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = gep_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == gep_pkg::S_CLEAR) begin
            r_clr_addr <= r_clr_addr + VADDR_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // Vertex id capture and reduction
    // ------------------------------------------------------------------------
    assign src_prod = PROD_W'(r_src_id) * PROD_W'(WRAP_RECIP);
    assign dst_prod = PROD_W'(r_dst_id) * PROD_W'(WRAP_RECIP);
    assign src_qn   = QN_W'(r_src_q) * QN_W'(WRAP_MOD);
    assign dst_qn   = QN_W'(r_dst_q) * QN_W'(WRAP_MOD);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_src_id <= i_source_vertex;
            r_dst_id <= i_dest_vertex;
        end
        // quotient estimate, low by at most one
        if (r_state == gep_pkg::S_WRAP_Q) begin
            r_src_q <= src_prod[PROD_W-1:32];
            r_dst_q <= dst_prod[PROD_W-1:32];
        end
        if (r_state == gep_pkg::S_WRAP_R) begin
            r_src_rem <= REM_W'(r_src_id) - src_qn[REM_W-1:0];
            r_dst_rem <= REM_W'(r_dst_id) - dst_qn[REM_W-1:0];
        end
    end

    assign src_addr = NEED_WRAP ? wrap_fold(r_src_rem) : VADDR_W'(r_src_id);
    assign dst_addr = NEED_WRAP ? wrap_fold(r_dst_rem) : VADDR_W'(r_dst_id);

    // ------------------------------------------------------------------------
    // Membership memory: two read ports, one write port
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_src_bits <= r_member_mem[src_addr];
            r_dst_bits <= r_member_mem[dst_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_member_mem[mem_waddr] <= mem_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // Candidate set and rule
    // ------------------------------------------------------------------------
    always_comb begin
        if (EFF_W'(r_active) == '0) begin
            eff_count = EFF_W'(1);
        end else if (EFF_W'(r_active) > EFF_W'(MAX_PARTITIONS)) begin
            eff_count = EFF_W'(MAX_PARTITIONS);
        end else begin
            eff_count = EFF_W'(r_active);
        end
    end

    for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_part
        assign part_mask[g] = (EFF_W'(g) < eff_count);
        assign load_vec[g]  = r_load[g];
    end

    assign src_m    = r_src_bits & part_mask;
    assign dst_m    = r_dst_bits & part_mask;
    assign shared_m = src_m & dst_m;
    assign union_m  = src_m | dst_m;

    always_comb begin
        priority if (shared_m != '0) begin
            cand_m    = shared_m;
            cand_rule = gep_pkg::RULE_SHARED;
        end else if (union_m != '0) begin
            cand_m    = union_m;
            cand_rule = gep_pkg::RULE_UNION;
        end else begin
            cand_m    = part_mask;
            cand_rule = gep_pkg::RULE_GLOBAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel_start) begin
            r_rule <= cand_rule;
        end
    end

    // ------------------------------------------------------------------------
    // Min-load search
    // ------------------------------------------------------------------------
    gep_least_loaded #(
        .NUM_PARTS (MAX_PARTITIONS),
        .LOAD_W    (LOAD_WIDTH)
    ) u_least_loaded (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sel_start),
        .i_sel   (cand_m),
        .i_loads (load_vec),
        .o_busy  (sel_busy),
        .o_index (sel_index)
    );

    // ------------------------------------------------------------------------
    // Load counters and result staging
    // ------------------------------------------------------------------------
    assign part_bit = MAX_PARTITIONS'(1) << sel_index;
    assign cur_load = r_load[sel_index];
    assign new_load = (cur_load == '1) ? cur_load : (cur_load + LOAD_WIDTH'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PARTITIONS; i++) begin
                r_load[i] <= '0;
            end
        end else if (res_en) begin
            r_load[sel_index] <= new_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_en) begin
            r_res_part <= gep_pkg::PART_W'(sel_index);
            r_res_rule <= r_rule;
            r_res_load <= gep_pkg::LOAD_OUT_W'(new_load);
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_part <= r_res_part;
            r_out_rule <= r_res_rule;
            r_out_load <= r_res_load;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_chosen_partition = r_out_part;
    assign o_rule_used        = r_out_rule;
    assign o_load_after       = r_out_load;

endmodule

`default_nettype wire

// File: rtl/gep_least_loaded.sv
// ----------------------------------------------------------------------------
// gep_least_loaded
// Iterative min-load search: one tree level per cycle over a node row that is
// reduced in place. Ties go to the lower partition index.
// ----------------------------------------------------------------------------
`default_nettype none

module gep_least_loaded #(
    parameter int NUM_PARTS = gep_pkg::MAX_PARTITIONS_DEF,
    parameter int LOAD_W    = gep_pkg::LOAD_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [NUM_PARTS-1:0]              i_sel,
    input  wire logic [NUM_PARTS-1:0][LOAD_W-1:0]  i_loads,
    output logic                                   o_busy,
    output logic [$clog2(NUM_PARTS)-1:0]           o_index
);

    localparam int LVLS   = $clog2(NUM_PARTS);
    localparam int IDX_W  = LVLS;
    localparam int LEAVES = 1 << LVLS;
    localparam int HALF   = LEAVES / 2;
    localparam int CNT_W  = (LVLS > 1) ? $clog2(LVLS) : 1;

    logic              r_busy;
    logic [CNT_W-1:0]  r_lvl;

    logic              r_node_ok   [LEAVES];
    logic [LOAD_W-1:0] r_node_load [LEAVES];
    logic [IDX_W-1:0]  r_node_idx  [LEAVES];

    logic              leaf_ok   [LEAVES];
    logic [LOAD_W-1:0] leaf_load [LEAVES];
    logic [IDX_W-1:0]  leaf_idx  [LEAVES];

    logic              red_ok   [HALF];
    logic [LOAD_W-1:0] red_load [HALF];
    logic [IDX_W-1:0]  red_idx  [HALF];

    // Leaves: selected partitions, padding slots never win
    for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
        if (g < NUM_PARTS) begin : g_used
            assign leaf_ok[g]   = i_sel[g];
            assign leaf_load[g] = i_loads[g];
            assign leaf_idx[g]  = IDX_W'(g);
        end else begin : g_pad
            assign leaf_ok[g]   = 1'b0;
            assign leaf_load[g] = '0;
            assign leaf_idx[g]  = '0;
        end
    end

    // One tree level: the lower node wins unless the upper one is strictly lighter
    for (genvar g = 0; g < HALF; g++) begin : g_pair
        logic take_lo;
        assign take_lo = r_node_ok[2*g] &&
                         (!r_node_ok[2*g+1] || (r_node_load[2*g] <= r_node_load[2*g+1]));
        assign red_ok[g]   = r_node_ok[2*g] || r_node_ok[2*g+1];
        assign red_load[g] = take_lo ? r_node_load[2*g] : r_node_load[2*g+1];
        assign red_idx[g]  = take_lo ? r_node_idx[2*g]  : r_node_idx[2*g+1];
    end

    // Level counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_lvl  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_lvl  <= '0;
        end else if (r_busy) begin
            if (r_lvl == CNT_W'(LVLS - 1)) begin
                r_busy <= 1'b0;
            end
            r_lvl <= r_lvl + CNT_W'(1);
        end
    end

    // Node row
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < LEAVES; i++) begin
                r_node_ok[i]   <= leaf_ok[i];
                r_node_load[i] <= leaf_load[i];
                r_node_idx[i]  <= leaf_idx[i];
            end
        end else if (r_busy) begin
            for (int i = 0; i < HALF; i++) begin
                r_node_ok[i]   <= red_ok[i];
                r_node_load[i] <= red_load[i];
                r_node_idx[i]  <= red_idx[i];
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_index = r_node_idx[0];

endmodule

`default_nettype wire

// File: rtl/gep_checker.sv
// ----------------------------------------------------------------------------
// gep_checker
// Port-level checks of the edge partitioner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_edge_partitioner_unit_assert.svh"

module gep_checker #(
    parameter int MAX_PARTITIONS = gep_pkg::MAX_PARTITIONS_DEF,
    parameter int LOAD_WIDTH     = gep_pkg::LOAD_WIDTH_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_ready,
    input wire logic                            o_valid,
    input wire logic                            i_ready,
    input wire logic [gep_pkg::PART_W-1:0]      o_chosen_partition,
    input wire logic [gep_pkg::RULE_W-1:0]      o_rule_used,
    input wire logic [gep_pkg::LOAD_OUT_W-1:0]  o_load_after,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic                            pready,
    input wire logic [gep_pkg::APB_ADDR_W-1:0]  paddr,
    input wire logic [gep_pkg::APB_DATA_W-1:0]  pwdata
);

    localparam int CFG_W   = gep_pkg::CFG_W;
    localparam int CNT_MIN = $clog2(MAX_PARTITIONS + 1);
    localparam int EFF_W   = (CNT_MIN > CFG_W) ? CNT_MIN : CFG_W;

    logic [1:0]       r_pending;
    logic [CFG_W-1:0] r_active;
    logic [EFF_W-1:0] eff_count;
    logic             in_acc, out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Edges taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_acc && !out_acc) begin
            r_pending <= r_pending + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_pending <= r_pending - 2'd1;
        end
    end

    // Mirror of the partition count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_W'(gep_pkg::active_reset(MAX_PARTITIONS));
        end else if (psel && penable && pwrite && pready &&
                     (paddr[gep_pkg::APB_ADDR_W-1:2] == gep_pkg::REG_ACTIVE)) begin
            r_active <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (EFF_W'(r_active) == '0) begin
            eff_count = EFF_W'(1);
        end else if (EFF_W'(r_active) > EFF_W'(MAX_PARTITIONS)) begin
            eff_count = EFF_W'(MAX_PARTITIONS);
        end else begin
            eff_count = EFF_W'(r_active);
        end
    end

    // No result word without an edge behind it
    `GEP_ASSERT_NOW(a_no_orphan_word, i_clk, i_rst_n, out_acc, r_pending != 2'd0, "result word without pending edge")

    // Ready only with no edge in progress: at most the waiting result is pending
    `GEP_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, o_ready, r_pending <= 2'd1, "ready while an edge is in progress")

    // Chosen partition lies within the active set
    `GEP_ASSERT_NOW(a_part_in_range, i_clk, i_rst_n, o_valid, EFF_W'(o_chosen_partition) < eff_count, "chosen partition outside active set")

    // Load after an assignment is never zero when it fits the port
    `GEP_ASSERT_NOW(a_load_nonzero, i_clk, i_rst_n, o_valid && (LOAD_WIDTH <= gep_pkg::LOAD_OUT_W), o_load_after != '0, "zero load after assignment")

    // A stalled result word holds
    `GEP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_chosen_partition) && $stable(o_rule_used) && $stable(o_load_after), "stalled result word changed")

endmodule

bind greedy_edge_partitioner_unit gep_checker #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .LOAD_WIDTH     (LOAD_WIDTH)
) u_gep_checker (.*);

`default_nettype wire

// File: tb/tb_greedy_edge_partitioner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_edge_partitioner_unit
// Self-checking bench for the greedy edge partitioner: edges are sent over a
// valid/ready channel, each result word is checked against an in-bench
// predictor that tracks the vertex partition bitmaps and partition loads.
// ----------------------------------------------------------------------------
module tb_greedy_edge_partitioner_unit;

    localparam int VERTEX_W       = gep_pkg::VERTEX_W;
    localparam int PART_W         = gep_pkg::PART_W;
    localparam int RULE_W         = gep_pkg::RULE_W;
    localparam int LOAD_OUT_W     = gep_pkg::LOAD_OUT_W;
    localparam int CFG_W          = gep_pkg::CFG_W;
    localparam int APB_ADDR_W     = gep_pkg::APB_ADDR_W;
    localparam int APB_DATA_W     = gep_pkg::APB_DATA_W;
    localparam int MAX_PARTS      = gep_pkg::MAX_PARTITIONS_DEF;
    localparam int VERTEX_COUNT   = gep_pkg::VERTEX_COUNT_DEF;
    localparam int LOAD_W         = gep_pkg::LOAD_WIDTH_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4 * VERTEX_COUNT;
    localparam logic [APB_ADDR_W-1:0] ACTIVE_ADDR =
        APB_ADDR_W'(4 * int'(gep_pkg::REG_ACTIVE));

    typedef struct packed {
        logic [PART_W-1:0]     part;
        logic [RULE_W-1:0]     rule;
        logic [LOAD_OUT_W-1:0] load;
    } t_edge_result;

    // DUT connections; the inputs are known from time zero
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  o_ready;
    logic [VERTEX_W-1:0]   i_source_vertex = '0;
    logic [VERTEX_W-1:0]   i_dest_vertex   = '0;
    logic                  o_valid;
    logic                  i_ready         = 1'b0;
    logic [PART_W-1:0]     o_chosen_partition;
    logic [RULE_W-1:0]     o_rule_used;
    logic [LOAD_OUT_W-1:0] o_load_after;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_DATA_W-1:0] pwdata          = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    bit [MAX_PARTS-1:0]          member_map [VERTEX_COUNT];
    bit [LOAD_W-1:0]             part_load [MAX_PARTS];
    int                          active_count = gep_pkg::active_reset(MAX_PARTS);
    t_edge_result                pending_results [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int error_count  = 0;
    int idle_cycles  = 0;

    greedy_edge_partitioner_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_source_vertex    (i_source_vertex),
        .i_dest_vertex      (i_dest_vertex),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_chosen_partition (o_chosen_partition),
        .o_rule_used        (o_rule_used),
        .o_load_after       (o_load_after),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Assign one edge: pick the partition, update bitmaps and load
    function automatic t_edge_result predict_edge(logic [VERTEX_W-1:0] src,
                                                  logic [VERTEX_W-1:0] dst);
        logic [MAX_PARTS-1:0] in_use;
        logic [MAX_PARTS-1:0] shared;
        logic [MAX_PARTS-1:0] either;
        logic [MAX_PARTS-1:0] candidates;
        logic [RULE_W-1:0]    rule;
        int                   best;
        bit                   found;
        t_edge_result         res;
        in_use = '0;
        for (int i = 0; i < active_count; i++) in_use[i] = 1'b1;
        // stale bits above the active count are masked off, not cleared
        shared = member_map[src] & member_map[dst] & in_use;
        either = (member_map[src] | member_map[dst]) & in_use;
        if (shared != '0) begin
            candidates = shared;
            rule       = gep_pkg::RULE_SHARED;
        end else if (either != '0) begin
            candidates = either;
            rule       = gep_pkg::RULE_UNION;
        end else begin
            candidates = in_use;
            rule       = gep_pkg::RULE_GLOBAL;
        end
        // least load, lowest index wins a tie
        best  = 0;
        found = 1'b0;
        for (int i = 0; i < MAX_PARTS; i++) begin
            if (candidates[i] && (!found || part_load[i] < part_load[best])) begin
                best  = i;
                found = 1'b1;
            end
        end
        member_map[src][best] = 1'b1;
        member_map[dst][best] = 1'b1;
        if (part_load[best] != '1) part_load[best]++;
        res.part = PART_W'(best);
        res.rule = rule;
        res.load = LOAD_OUT_W'(part_load[best]);
        return res;
    endfunction

    // Send one edge word; valid is left high for a back-to-back follower
    task automatic send_edge(input logic [VERTEX_W-1:0] src, input logic [VERTEX_W-1:0] dst);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_source_vertex <= src;
        i_dest_vertex   <= dst;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_results.push_back(predict_edge(src, dst));
    endtask

    // Stop sending and wait until every expected word is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Write the partition count while the unit is idle
    task automatic set_partitions(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ACTIVE_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // zero acts as one, anything above the build maximum as the maximum
        if (value == '0) active_count = 1;
        else if (int'(value) > MAX_PARTS) active_count = MAX_PARTS;
        else active_count = int'(value);
    endtask

    // Mostly a small pool so bitmaps overlap; some top-end and fully random ids
    function automatic logic [VERTEX_W-1:0] pick_vertex();
        int r;
        r = $urandom_range(99);
        if (r < 60) return VERTEX_W'($urandom_range(47));
        if (r < 80) return {{(VERTEX_W-4){1'b1}}, 4'($urandom_range(15))};
        return VERTEX_W'($urandom);
    endfunction

    // Global, union and shared picks, same endpoint twice, id extremes
    task automatic test_selection_rules();
        send_edge(16'h0000, 16'h0000);
        send_edge(16'hFFFF, 16'h0001);
        send_edge(16'h0000, 16'hFFFF);
        send_edge(16'h0000, 16'hFFFF);
        send_edge(16'hAAAA, 16'h5555);
        send_edge(16'h5555, 16'hAAAA);
        send_edge(16'h8000, 16'h7FFF);
        send_edge(16'h8000, 16'h0000);
    endtask

    // Small counts hide stale membership; zero and oversize counts are clamped
    task automatic test_partition_count();
        set_partitions(5'd3);
        send_edge(16'hAAAA, 16'h5555);
        send_edge(16'hFFFF, 16'h0000);
        send_edge(16'h0100, 16'h0200);
        send_edge(16'h0100, 16'h0300);
        set_partitions(5'd1);
        send_edge(16'h0100, 16'h0200);
        send_edge(16'hFFFF, 16'h8000);
        set_partitions(5'd0);
        send_edge(16'h0000, 16'h0001);
        send_edge(16'h7FFF, 16'h8000);
        set_partitions(5'd31);
        send_edge(16'hAAAA, 16'h0300);
        send_edge(16'h1234, 16'h1234);
        set_partitions(5'd17);
        send_edge(16'h5555, 16'hFFFF);
    endtask

    // Random edges under one idling profile, with a full drain midway and occasional random drains
    task automatic test_traffic(input int tx_idle, input int rx_stall,
                                input logic [CFG_W-1:0] parts, input int count);
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dst;
        set_partitions(parts);
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2 || $urandom_range(99) == 0) wait_drained();
            src = pick_vertex();
            dst = ($urandom_range(99) < 6) ? src : pick_vertex();
            send_edge(src, dst);
        end
    endtask

    // Receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_edge_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: partition %0d rule %0d load %0d",
                       o_chosen_partition, o_rule_used, o_load_after);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_chosen_partition !== want.part) begin
                    $error("chosen_partition: expected %0d, got %0d",
                           want.part, o_chosen_partition);
                    error_count++;
                end
                if (o_rule_used !== want.rule) begin
                    $error("rule_used: expected %0d, got %0d", want.rule, o_rule_used);
                    error_count++;
                end
                if (o_load_after !== want.load) begin
                    $error("load_after: expected %0d, got %0d", want.load, o_load_after);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no word moved and no register access
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_greedy_edge_partitioner_unit failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_selection_rules();
        test_partition_count();
        test_traffic(15, 56, 5'd5, 170);
        test_traffic(56, 15, 5'd16, 170);
        test_traffic(0, 0, 5'd8, 170);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_greedy_edge_partitioner_unit passed");
        end else begin
            $display("tb_greedy_edge_partitioner_unit failed");
        end
        $finish;
    end

endmodule
